[src/gvd_pkg.sv]
// shared types and constants for the group-varint decoder
`timescale 1ns / 1ps

package gvd_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] LAST_INDEX = 2'd3;

  typedef enum logic {
    KIND_MERGE,
    KIND_FINAL
  } gvd_kind_t;

  // one classified value byte on its way from front to back
  typedef struct packed {
    gvd_kind_t   kind;
    logic [1:0]  pos;
    logic [1:0]  idx;
    logic [7:0]  data;
  } gvd_entry_t;

endpackage

[src/gvd_if.sv]
// channel interfaces for the group-varint decoder
`timescale 1ns / 1ps

interface gvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
  modport mon    (input valid, input in_byte, input ready);
endinterface

interface gvd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  value_index;
  logic        group_last;

  modport source (output valid, output value, output value_index, output group_last,
                  input ready);
  modport sink   (input valid, input value, input value_index, input group_last,
                  output ready);
  modport mon    (input valid, input value, input value_index, input group_last,
                  input ready);
endinterface

[src/gvd_front.sv]
// front end: prefix tracking and value byte classification
`timescale 1ns / 1ps

module gvd_front import gvd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       push,
  output gvd_entry_t push_entry
);

  logic       expect_prefix_r, expect_prefix_nxt;
  logic [7:0] codes_r, codes_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] taken_r, taken_nxt;
  logic       accept;
  logic [1:0] code;
  logic       is_final;

  assign in_ready = rst_n && !q_full;
  assign accept   = in_valid && in_ready;
  assign code     = codes_r[{idx_r, 1'b0} +: 2];
  assign is_final = (taken_r == code);
  assign push     = accept && !expect_prefix_r;

  always_comb begin
    push_entry.kind = is_final ? KIND_FINAL : KIND_MERGE;
    push_entry.pos  = taken_r;
    push_entry.idx  = idx_r;
    push_entry.data = in_byte;
  end

  always_comb begin
    expect_prefix_nxt = expect_prefix_r;
    codes_nxt         = codes_r;
    idx_nxt           = idx_r;
    taken_nxt         = taken_r;
    if (accept) begin
      if (expect_prefix_r) begin
        codes_nxt         = in_byte;
        idx_nxt           = 2'd0;
        taken_nxt         = 2'd0;
        expect_prefix_nxt = 1'b0;
      end else if (is_final) begin
        taken_nxt = 2'd0;
        idx_nxt   = idx_r + 2'd1;
        if (idx_r == LAST_INDEX) expect_prefix_nxt = 1'b1;
      end else begin
        taken_nxt = taken_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_prefix_r <= 1'b1;
      codes_r         <= 8'd0;
      idx_r           <= 2'd0;
      taken_r         <= 2'd0;
    end else begin
      expect_prefix_r <= expect_prefix_nxt;
      codes_r         <= codes_nxt;
      idx_r           <= idx_nxt;
      taken_r         <= taken_nxt;
    end
  end

endmodule

[src/gvd_queue.sv]
// small fifo between front and back
`timescale 1ns / 1ps

module gvd_queue import gvd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gvd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output gvd_entry_t head_entry
);

  gvd_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/gvd_back.sv]
// back end: byte assembly and output register
`timescale 1ns / 1ps

module gvd_back import gvd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  gvd_entry_t  head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [1:0]  out_index,
  output logic        out_last
);

  logic [23:0] partial_r, partial_nxt;
  logic        valid_r, valid_nxt;
  logic [31:0] value_r, value_nxt;
  logic [1:0]  index_r, index_nxt;
  logic        last_r, last_nxt;
  logic        slot_free;
  logic [31:0] merged;

  assign slot_free = !valid_r || out_ready;
  assign pop = head_valid && ((head_entry.kind == KIND_MERGE) || slot_free);

  // place the byte at its lane on top of what is gathered so far
  always_comb begin
    merged = {8'd0, partial_r};
    unique case (head_entry.pos)
      2'd0: merged[7:0]   = merged[7:0]   | head_entry.data;
      2'd1: merged[15:8]  = merged[15:8]  | head_entry.data;
      2'd2: merged[23:16] = merged[23:16] | head_entry.data;
      2'd3: merged[31:24] = head_entry.data;
      default: merged = {8'd0, partial_r};
    endcase
  end

  always_comb begin
    partial_nxt = partial_r;
    valid_nxt   = valid_r;
    value_nxt   = value_r;
    index_nxt   = index_r;
    last_nxt    = last_r;
    if (valid_r && out_ready) valid_nxt = 1'b0;
    if (pop) begin
      if (head_entry.kind == KIND_MERGE) begin
        partial_nxt = merged[23:0];
      end else begin
        partial_nxt = 24'd0;
        valid_nxt   = 1'b1;
        value_nxt   = merged;
        index_nxt   = head_entry.idx;
        last_nxt    = (head_entry.idx == LAST_INDEX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 24'd0;
      valid_r   <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    index_r <= index_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_index = index_r;
  assign out_last  = last_r;

endmodule

[src/group_varint_decoder_unit.sv]
// top level of the group-varint decoder
`timescale 1ns / 1ps

// Decodes a group-varint stream of 32-bit values in groups of four, one
// stream byte per beat on in_ch. The first byte of a group is a prefix with
// four 2-bit length codes, lowest bits first; code k means k+1 little-endian
// bytes follow for that value. Prefix bytes produce no output; each value
// byte that completes a value produces one beat on out_ch with the value
// (zero-extended), its index in the group and a group_last flag on index 3.
// Rate: one byte per cycle sustained while the queue is not full, with no
// bubbles on prefix or value bytes. The front classifies the beat carrying
// a value's last byte, a two-entry queue holds it, and the back end
// assembles it into the output register. in_ch.ready drops only when the
// queue is full, which happens when out_ch stalls with a result pending
// and more bytes arrive. Ready is held low during reset.

module group_varint_decoder_unit import gvd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  gvd_in_if.sink   in_ch,
  gvd_out_if.source out_ch
);

  // front to queue
  logic       push;
  gvd_entry_t push_entry;
  logic       q_full;

  // queue to back
  logic       pop;
  logic       head_valid;
  gvd_entry_t head_entry;

  // prefix tracking and classification of each value byte
  gvd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.in_byte),
    .in_ready   (in_ch.ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the front from output back-pressure
  gvd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // merges bytes into the partial value and drives the result beat
  gvd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.value),
    .out_index  (out_ch.value_index),
    .out_last   (out_ch.group_last)
  );

endmodule

[src/gvd_checker.sv]
// port-level assertions for the group-varint decoder
`timescale 1ns / 1ps

module gvd_checker import gvd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_index,
  input logic        out_last
);

  // a pending result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_index) && $stable(out_last))
    else $error("result beat changed while stalled");

  // the group flag marks exactly the fourth value
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == LAST_INDEX)))
    else $error("group_last disagrees with value_index");

  // a fresh result always traces back to an accepted input beat, through the queue and the output register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching input beat");

endmodule

bind group_varint_decoder_unit gvd_checker u_gvd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .out_index (out_ch.value_index),
  .out_last  (out_ch.group_last)
);

[verif/testbench.sv]
// self-checking testbench for the group-varint decoder unit
`timescale 1ns / 1ps

module testbench;
  import gvd_pkg::*;

  // how busy one side of a channel is during a test
  typedef enum logic [1:0] {
    FLOW_FREE,    // never idles
    FLOW_JITTER,  // short gaps, now and then a long one
    FLOW_CHOKED   // idles most of the time, long stretches
  } flow_mode_t;

  // one decoded value as the result channel should present it
  typedef struct {
    logic [31:0] value;
    logic [1:0]  value_index;
    logic        group_last;
  } decoded_value_t;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 8;   // result passes the queue and the output register after its last byte
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic clk;
  logic rst_n;

  gvd_in_if  in_ch();
  gvd_out_if out_ch();

  group_varint_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // expected values, oldest first
  decoded_value_t pending_values[$];

  // stream position as the decoder should see it
  logic        want_prefix;
  logic [7:0]  group_codes;
  logic [1:0]  value_slot;
  logic [1:0]  bytes_seen;
  logic [23:0] low_bytes;

  flow_mode_t byte_flow;
  flow_mode_t value_flow;

  int fail_count;
  int bytes_sent;
  int values_checked;
  int groups_closed;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // idle length for one side: mostly none or short, a few long
  function automatic int pick_idle(input flow_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      FLOW_FREE: begin
        return 0;
      end
      FLOW_JITTER: begin
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
      default: begin
        if (roll < 25) return 0;
        if (roll < 60) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
    endcase
  endfunction

  // random byte with the all-zero and all-one patterns pulled in more often
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 8'h00;
    if (roll < 16) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // advance the expected stream state by one accepted byte
  task automatic track_stream_byte(input logic [7:0] b);
    logic [1:0]     code;
    logic [31:0]    full;
    decoded_value_t exp_val;
    if (want_prefix) begin
      // prefix: latch length codes and start the group over
      group_codes = b;
      value_slot  = 2'd0;
      bytes_seen  = 2'd0;
      low_bytes   = 24'd0;
      want_prefix = 1'b0;
      return;
    end
    code = group_codes[{value_slot, 1'b0} +: 2];
    if (bytes_seen < code) begin
      // not the last byte yet, merge it little-endian
      low_bytes[8 * bytes_seen +: 8] = b;
      bytes_seen = bytes_seen + 2'd1;
      return;
    end
    full = {8'h00, low_bytes};
    full[8 * bytes_seen +: 8] = b;
    exp_val.value       = full;
    exp_val.value_index = value_slot;
    exp_val.group_last  = (value_slot == LAST_INDEX);
    pending_values.push_back(exp_val);
    if (value_slot == LAST_INDEX) begin
      want_prefix = 1'b1;
      value_slot  = 2'd0;
    end else begin
      value_slot = value_slot + 2'd1;
    end
    bytes_seen = 2'd0;
    low_bytes  = 24'd0;
  endtask

  // one beat on the byte channel, with an optional gap in front of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_idle(byte_flow);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    track_stream_byte(b);
  endtask

  // a full group: prefix followed by the bytes its codes call for
  task automatic send_group(input logic [7:0] prefix);
    int nbytes;
    send_byte(prefix);
    for (int i = 0; i < 4; i++) begin
      nbytes = int'(prefix[2 * i +: 2]) + 1;
      for (int k = 0; k < nbytes; k++) send_byte(pick_byte());
    end
  endtask

  // result channel: check each beat, then decide ready for the next edge
  initial begin
    int stall_left;
    decoded_value_t exp_val;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_values.size() == 0) begin
          $error("unexpected result beat: value %h index %0d last %0b",
                 out_ch.value, out_ch.value_index, out_ch.group_last);
          fail_count++;
        end else begin
          exp_val = pending_values.pop_front();
          values_checked++;
          if (exp_val.group_last) groups_closed++;
          if (out_ch.value !== exp_val.value) begin
            $error("value: expected %h, got %h", exp_val.value, out_ch.value);
            fail_count++;
          end
          if (out_ch.value_index !== exp_val.value_index) begin
            $error("value_index: expected %0d, got %0d",
                   exp_val.value_index, out_ch.value_index);
            fail_count++;
          end
          if (out_ch.group_last !== exp_val.group_last) begin
            $error("group_last: expected %0b, got %0b",
                   exp_val.group_last, out_ch.group_last);
            fail_count++;
          end
        end
      end
      // back-pressure: hold ready low for a drawn number of cycles
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_idle(value_flow);
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // edge values: 1-byte group, mixed lengths rising, mixed lengths falling
  task automatic test_directed();
    byte_flow  = FLOW_JITTER;
    value_flow = FLOW_JITTER;
    // all four values one byte long
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);
    // lengths 1, 2, 3, 4: all-one or all-zero bytes at each size
    send_byte(8'he4);
    send_byte(8'hff);
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hff); send_byte(8'hff); send_byte(8'hff);
    send_byte(8'hff); send_byte(8'hff); send_byte(8'hff); send_byte(8'hff);
    // lengths 4, 3, 2, 1: top byte set, then walking patterns
    send_byte(8'h1b);
    send_byte(8'h01); send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
    send_byte(8'h55); send_byte(8'haa);
    send_byte(8'h7f);
  endtask

  // well-formed groups with random codes and content under mixed idling
  task automatic test_random_groups(input int byte_budget);
    int stop_at;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0: begin byte_flow = FLOW_FREE;   value_flow = FLOW_JITTER; end
        1: begin byte_flow = FLOW_JITTER; value_flow = FLOW_FREE;   end
        2: begin byte_flow = FLOW_JITTER; value_flow = FLOW_JITTER; end
        default: begin byte_flow = FLOW_FREE; value_flow = FLOW_FREE; end
      endcase
      repeat ($urandom_range(1, 4)) send_group(8'($urandom_range(0, 255)));
    end
  endtask

  // full rate both ways, the one-byte-per-cycle case
  task automatic test_back_to_back(input int byte_budget);
    int stop_at;
    byte_flow  = FLOW_FREE;
    value_flow = FLOW_FREE;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) send_group(8'($urandom_range(0, 255)));
  endtask

  // result side mostly stalled so the internal queue fills and in ready drops;
  // short groups make values frequent
  task automatic test_choked_output(input int byte_budget);
    int stop_at;
    byte_flow  = FLOW_FREE;
    value_flow = FLOW_CHOKED;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 1)) send_group(8'h00);
      else send_group(8'($urandom_range(0, 255)));
    end
  endtask

  // raw byte noise: any stream decodes, so this checks arbitrary alignment
  task automatic test_raw_noise(input int byte_count);
    byte_flow  = FLOW_JITTER;
    value_flow = FLOW_JITTER;
    repeat (byte_count) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int waited;
    fail_count     = 0;
    bytes_sent     = 0;
    values_checked = 0;
    groups_closed  = 0;
    want_prefix    = 1'b1;
    group_codes    = 8'h00;
    value_slot     = 2'd0;
    bytes_seen     = 2'd0;
    low_bytes      = 24'd0;
    byte_flow      = FLOW_FREE;
    value_flow     = FLOW_FREE;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    rst_n          = 1'b0;

    // synchronous reset, held low for RESET_CYCLES edges
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_groups(560);
    test_back_to_back(200);
    test_choked_output(160);
    test_raw_noise(80);
    in_ch.valid <= 1'b0;

    // let the last values drain, then wait TAIL_CYCLES for anything stray
    waited = 0;
    while (pending_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_values.size() != 0) begin
      $error("%0d expected values never arrived", pending_values.size());
      fail_count++;
    end

    $display("stream of %0d bytes decoded under varied flow, %0d values compared",
             bytes_sent, values_checked);
    $display("%0d groups closed, %0d failures", groups_closed, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
